[rtl/dsrr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Display slot ring receiver package
// Shared constants, codes and types of the slot ring receiver.
// ----------------------------------------------------------------------------
package dsrr_pkg;

  localparam int NUM_SLOTS = 2;
  localparam int BUF_BYTES = 32768;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int ALU_W     = 17;
  localparam int TICK_W    = 16;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd5000;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_RECEIVING,
    ST_READY,
    ST_DRAWING
  } slot_st_t;

  typedef enum logic [1:0] {
    REQ_RECT,
    REQ_DATA,
    REQ_POLL,
    REQ_OTHER
  } req_t;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_DRAW  = 2'd2;

  localparam logic [3:0] STS_NONE      = 4'd0;
  localparam logic [3:0] STS_RECT_OK   = 4'd1;
  localparam logic [3:0] STS_RECT_ABRT = 4'd2;
  localparam logic [3:0] STS_RECT_BUSY = 4'd3;
  localparam logic [3:0] STS_RECT_BAD  = 4'd4;
  localparam logic [3:0] STS_STORED    = 4'd5;
  localparam logic [3:0] STS_FRAME     = 4'd6;
  localparam logic [3:0] STS_DROPPED   = 4'd7;
  localparam logic [3:0] STS_UNKNOWN   = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_MUL,
    S_HDR_CHK,
    S_DAT_CMP,
    S_DAT_INC,
    S_DAT_FIN,
    S_POL_ADD,
    S_POL_CMP,
    S_POL_FREE,
    S_POL_DRW
  } seq_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             lt;
    logic             cout;
    logic [ALU_W-1:0] sum;
  } alu_res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (int'(s) + 1 >= NUM_SLOTS) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/dsrr_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot ring shared adder
// One adder that adds or subtracts and reports an unsigned less-than.
// ----------------------------------------------------------------------------
module dsrr_alu (
  input  var dsrr_pkg::alu_op_t               op,
  input  var logic [dsrr_pkg::ALU_W-1:0]      a,
  input  var logic [dsrr_pkg::ALU_W-1:0]      b,
  output dsrr_pkg::alu_res_t                  res
);

  logic [dsrr_pkg::ALU_W:0] full;

  always_comb begin
    case (op)
      dsrr_pkg::ALU_SUB: begin
        full = {1'b0, a} + {1'b0, ~b} + {{dsrr_pkg::ALU_W{1'b0}}, 1'b1};
      end
      default: begin
        full = {1'b0, a} + {1'b0, b};
      end
    endcase
    res.sum  = full[dsrr_pkg::ALU_W-1:0];
    res.cout = full[dsrr_pkg::ALU_W];
    res.lt   = (op == dsrr_pkg::ALU_SUB) && !full[dsrr_pkg::ALU_W];
  end

endmodule
`default_nettype wire

[rtl/display_slot_ring_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Display slot ring receiver core
// Receives rectangle headers, image bytes and polls for a ring of frame
// buffer slots, and issues byte stores and draw starts.
//
//   Channel  Ports                         Transfer
//   input    start, busy, in_*             start high while busy is low
//   result   out_valid, out_*              out_valid high for one cycle
//   config   cfg_valid, cfg_ready, cfg_*   cfg_valid and cfg_ready high
//
// An unknown command gives its result in the cycle after the transfer.
// A header runs up to multiply and check steps, an image byte compare,
// increment and finish steps and a poll add, compare, free and draw steps;
// the header size comes from one 8 by 8 product, and every less-than compare
// and count step runs through the one shared 17-bit adder and comparator.
// Synchronous reset empties all slots and loads the timeout with 5000.
// Results cannot be stalled; busy is high while an item is in work.
// ----------------------------------------------------------------------------
module display_slot_ring_receiver_core (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        start,
  output logic            busy,
  input  var logic [1:0]  in_req_type,
  input  var logic [7:0]  in_rect_x,
  input  var logic [7:0]  in_rect_y,
  input  var logic [7:0]  in_rect_w,
  input  var logic [7:0]  in_rect_h,
  input  var logic [7:0]  in_data_byte,
  input  var logic        in_dma_busy,
  input  var logic [7:0]  in_elapsed_ticks,
  output logic            out_valid,
  output logic [1:0]      out_action,
  output logic            out_slot,
  output logic [14:0]     out_offset,
  output logic [7:0]      out_store_byte,
  output logic [7:0]      out_draw_x,
  output logic [7:0]      out_draw_y,
  output logic [7:0]      out_draw_w,
  output logic [7:0]      out_draw_h,
  output logic [15:0]     out_byte_count,
  output logic [3:0]      out_status,
  output logic            out_timed_out,
  output logic            out_slot_freed,
  input  var logic        cfg_valid,
  output logic            cfg_ready,
  input  var logic [15:0] cfg_timeout_ticks
);

  localparam int NS  = dsrr_pkg::NUM_SLOTS;
  localparam int SW  = dsrr_pkg::SLOT_W;
  localparam int CW  = dsrr_pkg::CNT_W;
  localparam int AW  = dsrr_pkg::ALU_W;
  localparam int TW  = dsrr_pkg::TICK_W;

  dsrr_pkg::seq_t     state_r, state_nxt;
  dsrr_pkg::slot_st_t slot_st_r [NS];
  dsrr_pkg::slot_st_t slot_st_nxt [NS];
  logic [CW-1:0]      filled_r [NS];
  logic [CW-1:0]      filled_nxt [NS];
  logic [CW-1:0]      total_r [NS];
  logic [7:0]         reg_x_r [NS];
  logic [7:0]         reg_y_r [NS];
  logic [7:0]         reg_w_r [NS];
  logic [7:0]         reg_h_r [NS];
  logic               hdr_we;

  logic [SW-1:0]      write_slot_r, write_slot_nxt;
  logic [SW-1:0]      draw_slot_r, draw_slot_nxt;
  logic [TW-1:0]      idle_r, idle_nxt;
  logic [TW-1:0]      timeout_r;
  logic [AW-1:0]      tot_r, tot_nxt;
  logic               abort_r, abort_nxt;
  logic               lt_r, lt_nxt;

  logic [7:0]         x_r, y_r, w_r, h_r, byte_r, el_r;
  logic               dma_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_action_r, out_action_nxt;
  logic [SW-1:0]      out_slot_r, out_slot_nxt;
  logic [14:0]        out_offset_r, out_offset_nxt;
  logic [7:0]         out_store_byte_r, out_store_byte_nxt;
  logic [7:0]         out_draw_x_r, out_draw_x_nxt;
  logic [7:0]         out_draw_y_r, out_draw_y_nxt;
  logic [7:0]         out_draw_w_r, out_draw_w_nxt;
  logic [7:0]         out_draw_h_r, out_draw_h_nxt;
  logic [15:0]        out_byte_count_r, out_byte_count_nxt;
  logic [3:0]         out_status_r, out_status_nxt;
  logic               out_timed_out_r, out_timed_out_nxt;
  logic               out_slot_freed_r, out_slot_freed_nxt;

  logic               accept;
  logic [SW-1:0]      sel;
  dsrr_pkg::slot_st_t sel_st;
  logic [CW-1:0]      sel_filled;
  logic [CW-1:0]      sel_total;

  dsrr_pkg::alu_op_t  alu_op;
  logic [AW-1:0]      alu_a, alu_b;
  dsrr_pkg::alu_res_t alu_res;

  dsrr_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign accept    = start && (state_r == dsrr_pkg::S_IDLE);
  assign busy      = (state_r != dsrr_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign sel = ((state_r == dsrr_pkg::S_POL_FREE) || (state_r == dsrr_pkg::S_POL_DRW)) ?
               draw_slot_r : write_slot_r;
  assign sel_st     = slot_st_r[sel];
  assign sel_filled = filled_r[sel];
  assign sel_total  = total_r[sel];

  always_comb begin
    alu_op = dsrr_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      dsrr_pkg::S_HDR_CHK: begin
        alu_op = dsrr_pkg::ALU_SUB;
        alu_a  = AW'(dsrr_pkg::BUF_BYTES);
        alu_b  = tot_r;
      end
      dsrr_pkg::S_DAT_CMP, dsrr_pkg::S_DAT_FIN: begin
        alu_op = dsrr_pkg::ALU_SUB;
        alu_a  = AW'(sel_filled);
        alu_b  = AW'(sel_total);
      end
      dsrr_pkg::S_DAT_INC: begin
        alu_a = AW'(sel_filled);
        alu_b = AW'(1);
      end
      dsrr_pkg::S_POL_ADD: begin
        alu_a = AW'(idle_r);
        alu_b = AW'(el_r);
      end
      dsrr_pkg::S_POL_CMP: begin
        alu_op = dsrr_pkg::ALU_SUB;
        alu_a  = AW'(idle_r);
        alu_b  = AW'(timeout_r);
      end
      default: begin
        alu_op = dsrr_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsrr_pkg::S_IDLE: begin
        if (start) begin
          case (dsrr_pkg::req_t'(in_req_type))
            dsrr_pkg::REQ_RECT: state_nxt = dsrr_pkg::S_HDR_MUL;
            dsrr_pkg::REQ_DATA: state_nxt = dsrr_pkg::S_DAT_CMP;
            dsrr_pkg::REQ_POLL: state_nxt = dsrr_pkg::S_POL_ADD;
            default:            state_nxt = dsrr_pkg::S_IDLE;
          endcase
        end
      end
      dsrr_pkg::S_HDR_MUL: begin
        if (sel_st inside {dsrr_pkg::ST_READY, dsrr_pkg::ST_DRAWING}) begin
          state_nxt = dsrr_pkg::S_IDLE;
        end else begin
          state_nxt = dsrr_pkg::S_HDR_CHK;
        end
      end
      dsrr_pkg::S_HDR_CHK: state_nxt = dsrr_pkg::S_IDLE;
      dsrr_pkg::S_DAT_CMP: begin
        if (sel_st != dsrr_pkg::ST_RECEIVING) begin
          state_nxt = dsrr_pkg::S_IDLE;
        end else begin
          state_nxt = dsrr_pkg::S_DAT_INC;
        end
      end
      dsrr_pkg::S_DAT_INC:  state_nxt = dsrr_pkg::S_DAT_FIN;
      dsrr_pkg::S_DAT_FIN:  state_nxt = dsrr_pkg::S_IDLE;
      dsrr_pkg::S_POL_ADD:  state_nxt = dsrr_pkg::S_POL_CMP;
      dsrr_pkg::S_POL_CMP:  state_nxt = dsrr_pkg::S_POL_FREE;
      dsrr_pkg::S_POL_FREE: begin
        if ((sel_st == dsrr_pkg::ST_DRAWING) && dma_r) begin
          state_nxt = dsrr_pkg::S_IDLE;
        end else begin
          state_nxt = dsrr_pkg::S_POL_DRW;
        end
      end
      dsrr_pkg::S_POL_DRW:  state_nxt = dsrr_pkg::S_IDLE;
      default:              state_nxt = dsrr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    slot_st_nxt        = slot_st_r;
    filled_nxt         = filled_r;
    hdr_we             = 1'b0;
    write_slot_nxt     = write_slot_r;
    draw_slot_nxt      = draw_slot_r;
    idle_nxt           = idle_r;
    tot_nxt            = tot_r;
    abort_nxt          = abort_r;
    lt_nxt             = lt_r;
    out_valid_nxt      = 1'b0;
    out_action_nxt     = out_action_r;
    out_slot_nxt       = out_slot_r;
    out_offset_nxt     = out_offset_r;
    out_store_byte_nxt = out_store_byte_r;
    out_draw_x_nxt     = out_draw_x_r;
    out_draw_y_nxt     = out_draw_y_r;
    out_draw_w_nxt     = out_draw_w_r;
    out_draw_h_nxt     = out_draw_h_r;
    out_byte_count_nxt = out_byte_count_r;
    out_status_nxt     = out_status_r;
    out_timed_out_nxt  = out_timed_out_r;
    out_slot_freed_nxt = out_slot_freed_r;
    case (state_r)
      dsrr_pkg::S_IDLE: begin
        if (start) begin
          out_action_nxt     = dsrr_pkg::ACT_NONE;
          out_slot_nxt       = '0;
          out_offset_nxt     = '0;
          out_store_byte_nxt = '0;
          out_draw_x_nxt     = '0;
          out_draw_y_nxt     = '0;
          out_draw_w_nxt     = '0;
          out_draw_h_nxt     = '0;
          out_byte_count_nxt = '0;
          out_status_nxt     = dsrr_pkg::STS_NONE;
          out_timed_out_nxt  = 1'b0;
          out_slot_freed_nxt = 1'b0;
          abort_nxt          = 1'b0;
          if (dsrr_pkg::req_t'(in_req_type) != dsrr_pkg::REQ_POLL) begin
            idle_nxt = '0;
          end
          if (dsrr_pkg::req_t'(in_req_type) == dsrr_pkg::REQ_OTHER) begin
            out_status_nxt = dsrr_pkg::STS_UNKNOWN;
            out_valid_nxt  = 1'b1;
          end
        end
      end
      dsrr_pkg::S_HDR_MUL: begin
        tot_nxt = {({8'd0, w_r} * {8'd0, h_r}), 1'b0};
        if (sel_st inside {dsrr_pkg::ST_READY, dsrr_pkg::ST_DRAWING}) begin
          out_status_nxt = dsrr_pkg::STS_RECT_BUSY;
          out_valid_nxt  = 1'b1;
        end else if (sel_st == dsrr_pkg::ST_RECEIVING) begin
          abort_nxt       = 1'b1;
          filled_nxt[sel] = '0;
        end
      end
      dsrr_pkg::S_HDR_CHK: begin
        out_valid_nxt = 1'b1;
        if ((tot_r == '0) || alu_res.lt) begin
          out_status_nxt = dsrr_pkg::STS_RECT_BAD;
        end else begin
          hdr_we           = 1'b1;
          slot_st_nxt[sel] = dsrr_pkg::ST_RECEIVING;
          filled_nxt[sel]  = '0;
          out_status_nxt   = abort_r ? dsrr_pkg::STS_RECT_ABRT : dsrr_pkg::STS_RECT_OK;
        end
      end
      dsrr_pkg::S_DAT_CMP: begin
        lt_nxt = alu_res.lt;
        if (sel_st != dsrr_pkg::ST_RECEIVING) begin
          out_status_nxt = dsrr_pkg::STS_DROPPED;
          out_valid_nxt  = 1'b1;
        end
      end
      dsrr_pkg::S_DAT_INC: begin
        if (lt_r) begin
          out_action_nxt     = dsrr_pkg::ACT_STORE;
          out_slot_nxt       = sel;
          out_offset_nxt     = sel_filled[14:0];
          out_store_byte_nxt = byte_r;
          filled_nxt[sel]    = alu_res.sum[CW-1:0];
        end
      end
      dsrr_pkg::S_DAT_FIN: begin
        out_valid_nxt = 1'b1;
        if (!alu_res.lt) begin
          slot_st_nxt[sel] = dsrr_pkg::ST_READY;
          write_slot_nxt   = dsrr_pkg::next_slot(sel);
          out_status_nxt   = dsrr_pkg::STS_FRAME;
        end else begin
          out_status_nxt = dsrr_pkg::STS_STORED;
        end
      end
      dsrr_pkg::S_POL_ADD: begin
        if (alu_res.sum[TW]) begin
          idle_nxt = '1;
        end else begin
          idle_nxt = alu_res.sum[TW-1:0];
        end
      end
      dsrr_pkg::S_POL_CMP: begin
        if ((sel_st == dsrr_pkg::ST_RECEIVING) && !alu_res.lt) begin
          filled_nxt[sel]   = '0;
          slot_st_nxt[sel]  = dsrr_pkg::ST_EMPTY;
          out_timed_out_nxt = 1'b1;
        end
      end
      dsrr_pkg::S_POL_FREE: begin
        if (sel_st == dsrr_pkg::ST_DRAWING) begin
          if (dma_r) begin
            out_valid_nxt = 1'b1;
          end else begin
            slot_st_nxt[sel]   = dsrr_pkg::ST_EMPTY;
            draw_slot_nxt      = dsrr_pkg::next_slot(sel);
            out_slot_freed_nxt = 1'b1;
          end
        end
      end
      dsrr_pkg::S_POL_DRW: begin
        out_valid_nxt = 1'b1;
        if ((sel_st == dsrr_pkg::ST_READY) && !dma_r) begin
          out_action_nxt     = dsrr_pkg::ACT_DRAW;
          out_slot_nxt       = sel;
          out_draw_x_nxt     = reg_x_r[sel];
          out_draw_y_nxt     = reg_y_r[sel];
          out_draw_w_nxt     = reg_w_r[sel];
          out_draw_h_nxt     = reg_h_r[sel];
          out_byte_count_nxt = 16'(sel_filled);
          slot_st_nxt[sel]   = dsrr_pkg::ST_DRAWING;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dsrr_pkg::S_IDLE;
      write_slot_r <= '0;
      draw_slot_r  <= '0;
      idle_r       <= '0;
      timeout_r    <= dsrr_pkg::TIMEOUT_RST;
      out_valid_r  <= 1'b0;
      abort_r      <= 1'b0;
      lt_r         <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        slot_st_r[i] <= dsrr_pkg::ST_EMPTY;
        filled_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      draw_slot_r  <= draw_slot_nxt;
      idle_r       <= idle_nxt;
      out_valid_r  <= out_valid_nxt;
      abort_r      <= abort_nxt;
      lt_r         <= lt_nxt;
      slot_st_r    <= slot_st_nxt;
      filled_r     <= filled_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    tot_r            <= tot_nxt;
    out_action_r     <= out_action_nxt;
    out_slot_r       <= out_slot_nxt;
    out_offset_r     <= out_offset_nxt;
    out_store_byte_r <= out_store_byte_nxt;
    out_draw_x_r     <= out_draw_x_nxt;
    out_draw_y_r     <= out_draw_y_nxt;
    out_draw_w_r     <= out_draw_w_nxt;
    out_draw_h_r     <= out_draw_h_nxt;
    out_byte_count_r <= out_byte_count_nxt;
    out_status_r     <= out_status_nxt;
    out_timed_out_r  <= out_timed_out_nxt;
    out_slot_freed_r <= out_slot_freed_nxt;
    if (accept) begin
      x_r    <= in_rect_x;
      y_r    <= in_rect_y;
      w_r    <= in_rect_w;
      h_r    <= in_rect_h;
      byte_r <= in_data_byte;
      dma_r  <= in_dma_busy;
      el_r   <= in_elapsed_ticks;
    end
    if (hdr_we) begin
      reg_x_r[sel] <= x_r;
      reg_y_r[sel] <= y_r;
      reg_w_r[sel] <= w_r;
      reg_h_r[sel] <= h_r;
      total_r[sel] <= tot_r[CW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_slot       = out_slot_r;
  assign out_offset     = out_offset_r;
  assign out_store_byte = out_store_byte_r;
  assign out_draw_x     = out_draw_x_r;
  assign out_draw_y     = out_draw_y_r;
  assign out_draw_w     = out_draw_w_r;
  assign out_draw_h     = out_draw_h_r;
  assign out_byte_count = out_byte_count_r;
  assign out_status     = out_status_r;
  assign out_timed_out  = out_timed_out_r;
  assign out_slot_freed = out_slot_freed_r;

endmodule
`default_nettype wire
